// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// Min/max spread statistics package
// Widths, the queue entry type and sample helpers shared across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

  localparam int unsigned MaxBunches = 4096;
  localparam int unsigned SampleBits = 16;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SpreadW = 17;
  localparam int unsigned MagW    = 16;
  localparam int unsigned SqW     = 2 * MagW;
  localparam int unsigned CountW  = 13;
  localparam int unsigned SumW    = 29;
  localparam int unsigned SqSumW  = 44;
  localparam int unsigned VarW    = 56;
  localparam int unsigned ProdW   = CountW + SqSumW;
  localparam int unsigned SumSqW  = 2 * SumW;

  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam int unsigned NarrowSh = SampleW - SampleBits;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    logic signed [SpreadW-1:0] spread;
    logic [SqW-1:0]            spread_sq;
    logic [MagW-1:0]           peak_mag;
    logic [MagW-1:0]           peak_spread;
    logic [CountW-1:0]         count;
    logic                      last;
  } entry_t;

  function automatic sample_t narrow_sample(sample_t raw);
    sample_t t;
    t = raw <<< NarrowSh;
    return t >>> NarrowSh;
  endfunction

  function automatic logic [MagW-1:0] sample_mag(sample_t v);
    sample_t n;
    n = -v;
    return v[SampleW-1] ? MagW'($unsigned(n)) : MagW'($unsigned(v));
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mss_intf.sv =====
// ----------------------------------------------------------------------------
// Min/max spread statistics channels
// Bunch sample request channel and per-bunch result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface mss_bunch_if;
  logic                                valid;
  logic                                ready;
  logic signed [mss_pkg::SampleW-1:0]  min_sample;
  logic signed [mss_pkg::SampleW-1:0]  max_sample;
  logic                                end_of_turn;

  modport source (output valid, output min_sample, output max_sample,
                  output end_of_turn, input ready);
  modport sink   (input valid, input min_sample, input max_sample,
                  input end_of_turn, output ready);
endinterface

interface mss_stats_if;
  logic                               valid;
  logic                               ready;
  logic signed [mss_pkg::SpreadW-1:0] spread;
  logic                               stats_valid;
  logic [mss_pkg::CountW-1:0]         bunch_count;
  logic signed [mss_pkg::SumW-1:0]    spread_sum;
  logic [mss_pkg::SqSumW-1:0]         spread_square_sum;
  logic [mss_pkg::MagW-1:0]           peak_magnitude;
  logic [mss_pkg::MagW-1:0]           peak_spread;
  logic [mss_pkg::VarW-1:0]           variance_numerator;

  modport source (output valid, output spread, output stats_valid,
                  output bunch_count, output spread_sum, output spread_square_sum,
                  output peak_magnitude, output peak_spread,
                  output variance_numerator, input ready);
  modport sink   (input valid, input spread, input stats_valid,
                  input bunch_count, input spread_sum, input spread_square_sum,
                  input peak_magnitude, input peak_spread,
                  input variance_numerator, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mss_front.sv =====
// ----------------------------------------------------------------------------
// Min/max spread statistics front end
// Accepts bunch requests, forms spread, square and peak candidates, and marks
// the end of the turn, including the bunch limit.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  mss_bunch_if.sink             bunch_i,
  output logic                  push_valid_o,
  output mss_pkg::entry_t       push_entry_o,
  input  wire logic             push_ready_i
);

  logic [mss_pkg::CountW-1:0]         cnt_q, cnt_d;
  logic [mss_pkg::CountW-1:0]         cnt_next;
  mss_pkg::sample_t                   lo, hi;
  logic signed [mss_pkg::SpreadW-1:0] spread;
  logic signed [mss_pkg::SpreadW-1:0] spread_neg;
  logic [mss_pkg::MagW-1:0]           spread_mag;
  logic [mss_pkg::MagW-1:0]           mag_lo, mag_hi;
  logic                               last;
  logic                               accept;

  assign bunch_i.ready = push_ready_i;
  assign push_valid_o  = bunch_i.valid;
  assign accept        = bunch_i.valid && push_ready_i;

  always_comb begin
    lo         = mss_pkg::narrow_sample(bunch_i.min_sample);
    hi         = mss_pkg::narrow_sample(bunch_i.max_sample);
    spread     = mss_pkg::SpreadW'(hi) - mss_pkg::SpreadW'(lo);
    spread_neg = -spread;
    spread_mag = spread[mss_pkg::SpreadW-1] ? spread_neg[mss_pkg::MagW-1:0]
                                            : spread[mss_pkg::MagW-1:0];
    mag_lo     = mss_pkg::sample_mag(lo);
    mag_hi     = mss_pkg::sample_mag(hi);
    cnt_next   = cnt_q + 1'b1;
    last       = bunch_i.end_of_turn ||
                 (cnt_next >= mss_pkg::CountW'(mss_pkg::MaxBunches));

    push_entry_o.spread      = spread;
    push_entry_o.spread_sq   = mss_pkg::SqW'(spread_mag) * mss_pkg::SqW'(spread_mag);
    push_entry_o.peak_mag    = (mag_hi > mag_lo) ? mag_hi : mag_lo;
    push_entry_o.peak_spread = (!spread[mss_pkg::SpreadW-1] && (spread != '0))
                               ? spread[mss_pkg::MagW-1:0] : '0;
    push_entry_o.count       = cnt_next;
    push_entry_o.last        = last;

    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = last ? '0 : cnt_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mss_queue.sv =====
// ----------------------------------------------------------------------------
// Min/max spread statistics queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  input  wire mss_pkg::entry_t  push_entry_i,
  output logic                  push_ready_o,
  output logic                  pop_valid_o,
  output mss_pkg::entry_t       pop_entry_o,
  input  wire logic             pop_ready_i
);

  mss_pkg::entry_t           mem_q [mss_pkg::QDepth];
  logic [mss_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [mss_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [mss_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic                      push, pop;

  assign push_ready_o = (cnt_q != mss_pkg::QCntW'(mss_pkg::QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mss_back.sv =====
// ----------------------------------------------------------------------------
// Min/max spread statistics back end
// Accumulates the turn totals, forms the variance numerator in two further
// stages and holds the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             pop_valid_i,
  input  wire mss_pkg::entry_t  pop_entry_i,
  output logic                  pop_ready_o,
  mss_stats_if.source           stats_o
);

  // turn accumulators
  logic signed [mss_pkg::SumW-1:0]    acc_sum_q, acc_sum_d;
  logic [mss_pkg::SqSumW-1:0]         acc_sqsum_q, acc_sqsum_d;
  logic [mss_pkg::MagW-1:0]           acc_pmag_q, acc_pmag_d;
  logic [mss_pkg::MagW-1:0]           acc_pspr_q, acc_pspr_d;

  logic signed [mss_pkg::SumW-1:0]    sum_n;
  logic [mss_pkg::SqSumW-1:0]         sqsum_n;
  logic [mss_pkg::MagW-1:0]           pmag_n, pspr_n;

  // accumulate stage
  logic                               v1_q, v1_d;
  logic signed [mss_pkg::SpreadW-1:0] s1_spread_q;
  logic                               s1_stats_q;
  logic [mss_pkg::CountW-1:0]         s1_count_q;
  logic signed [mss_pkg::SumW-1:0]    s1_sum_q;
  logic [mss_pkg::SqSumW-1:0]         s1_sqsum_q;
  logic [mss_pkg::MagW-1:0]           s1_pmag_q, s1_pspr_q;

  // product stage
  logic                               v2_q, v2_d;
  logic signed [mss_pkg::SpreadW-1:0] s2_spread_q;
  logic                               s2_stats_q;
  logic [mss_pkg::CountW-1:0]         s2_count_q;
  logic signed [mss_pkg::SumW-1:0]    s2_sum_q;
  logic [mss_pkg::SqSumW-1:0]         s2_sqsum_q;
  logic [mss_pkg::MagW-1:0]           s2_pmag_q, s2_pspr_q;
  logic [mss_pkg::VarW-1:0]           s2_prod_q, s2_sq_q;
  logic [mss_pkg::ProdW-1:0]          prod_full;
  logic signed [mss_pkg::SumSqW-1:0]  sq_full;

  // output stage
  logic                               v3_q, v3_d;

  logic                               s1_rdy, s2_rdy, s3_rdy;
  logic                               pop, mv12, mv23;

  assign s3_rdy      = !v3_q || stats_o.ready;
  assign s2_rdy      = !v2_q || s3_rdy;
  assign s1_rdy      = !v1_q || s2_rdy;
  assign pop_ready_o = s1_rdy;
  assign pop         = pop_valid_i && s1_rdy;
  assign mv12        = v1_q && s2_rdy;
  assign mv23        = v2_q && s3_rdy;
  assign stats_o.valid = v3_q;

  always_comb begin
    sum_n   = acc_sum_q + mss_pkg::SumW'(pop_entry_i.spread);
    sqsum_n = acc_sqsum_q + mss_pkg::SqSumW'(pop_entry_i.spread_sq);
    pmag_n  = (pop_entry_i.peak_mag > acc_pmag_q) ? pop_entry_i.peak_mag : acc_pmag_q;
    pspr_n  = (pop_entry_i.peak_spread > acc_pspr_q) ? pop_entry_i.peak_spread
                                                     : acc_pspr_q;

    acc_sum_d   = acc_sum_q;
    acc_sqsum_d = acc_sqsum_q;
    acc_pmag_d  = acc_pmag_q;
    acc_pspr_d  = acc_pspr_q;
    if (pop) begin
      acc_sum_d   = pop_entry_i.last ? '0 : sum_n;
      acc_sqsum_d = pop_entry_i.last ? '0 : sqsum_n;
      acc_pmag_d  = pop_entry_i.last ? '0 : pmag_n;
      acc_pspr_d  = pop_entry_i.last ? '0 : pspr_n;
    end

    v1_d = pop  ? 1'b1 : (mv12 ? 1'b0 : v1_q);
    v2_d = mv12 ? 1'b1 : (mv23 ? 1'b0 : v2_q);
    v3_d = mv23 ? 1'b1 : ((v3_q && stats_o.ready) ? 1'b0 : v3_q);

    prod_full = mss_pkg::ProdW'(s1_count_q) * mss_pkg::ProdW'(s1_sqsum_q);
    sq_full   = mss_pkg::SumSqW'(s1_sum_q) * mss_pkg::SumSqW'(s1_sum_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_sum_q   <= '0;
      acc_sqsum_q <= '0;
      acc_pmag_q  <= '0;
      acc_pspr_q  <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
    end else begin
      acc_sum_q   <= acc_sum_d;
      acc_sqsum_q <= acc_sqsum_d;
      acc_pmag_q  <= acc_pmag_d;
      acc_pspr_q  <= acc_pspr_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      v3_q        <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_spread_q <= pop_entry_i.spread;
      s1_stats_q  <= pop_entry_i.last;
      s1_count_q  <= pop_entry_i.last ? pop_entry_i.count : '0;
      s1_sum_q    <= pop_entry_i.last ? sum_n : '0;
      s1_sqsum_q  <= pop_entry_i.last ? sqsum_n : '0;
      s1_pmag_q   <= pop_entry_i.last ? pmag_n : '0;
      s1_pspr_q   <= pop_entry_i.last ? pspr_n : '0;
    end
    if (mv12) begin
      s2_spread_q <= s1_spread_q;
      s2_stats_q  <= s1_stats_q;
      s2_count_q  <= s1_count_q;
      s2_sum_q    <= s1_sum_q;
      s2_sqsum_q  <= s1_sqsum_q;
      s2_pmag_q   <= s1_pmag_q;
      s2_pspr_q   <= s1_pspr_q;
      s2_prod_q   <= prod_full[mss_pkg::VarW-1:0];
      s2_sq_q     <= sq_full[mss_pkg::VarW-1:0];
    end
    if (mv23) begin
      stats_o.spread             <= s2_spread_q;
      stats_o.stats_valid        <= s2_stats_q;
      stats_o.bunch_count        <= s2_count_q;
      stats_o.spread_sum         <= s2_sum_q;
      stats_o.spread_square_sum  <= s2_sqsum_q;
      stats_o.peak_magnitude     <= s2_pmag_q;
      stats_o.peak_spread        <= s2_pspr_q;
      stats_o.variance_numerator <= s2_prod_q - s2_sq_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/minmax_spread_statistics.sv =====
// ----------------------------------------------------------------------------
// Min/max spread statistics
// Per-bunch spread with turn sums, peaks and variance numerator.
// A result passes the queue, the accumulate and product stages and the output
// register. Throughput: one bunch per cycle until the four-entry queue fills;
// with the output register it keeps the input open while a result waits.
// Reset clears the turn accumulators, the bunch counter, the queue and all
// pipeline valids; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module minmax_spread_statistics (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mss_bunch_if.sink   bunch_i,
  mss_stats_if.source stats_o
);

  logic            push_valid, push_ready;
  mss_pkg::entry_t push_entry;
  logic            pop_valid, pop_ready;
  mss_pkg::entry_t pop_entry;

  mss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bunch_i      (bunch_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  mss_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  mss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_ready_o (pop_ready),
    .stats_o     (stats_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mss_checker.sv =====
// ----------------------------------------------------------------------------
// Min/max spread statistics checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mss_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               out_valid_i,
  input wire logic                               out_ready_i,
  input wire logic signed [mss_pkg::SpreadW-1:0] spread_i,
  input wire logic                               stats_valid_i,
  input wire logic [mss_pkg::CountW-1:0]         bunch_count_i,
  input wire logic signed [mss_pkg::SumW-1:0]    spread_sum_i,
  input wire logic [mss_pkg::SqSumW-1:0]         spread_square_sum_i,
  input wire logic [mss_pkg::VarW-1:0]           variance_numerator_i
);

  `MSS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(spread_i) && $stable(variance_numerator_i),
    "result dropped or changed while stalled")

  `MSS_ASSERT_NOW(a_idle_totals_zero, out_valid_i && !stats_valid_i,
    bunch_count_i == '0 && spread_sum_i == '0 && spread_square_sum_i == '0 &&
    variance_numerator_i == '0,
    "turn totals shown on a bunch that does not end the turn")

  `MSS_ASSERT_NOW(a_count_range, out_valid_i && stats_valid_i,
    bunch_count_i != '0 &&
    bunch_count_i <= mss_pkg::CountW'(mss_pkg::MaxBunches),
    "bunch count out of range at end of turn")

  `MSS_ASSERT_NOW(a_single_bunch, out_valid_i && stats_valid_i && bunch_count_i == 13'd1,
    variance_numerator_i == '0 && spread_sum_i == mss_pkg::SumW'(spread_i),
    "single-bunch turn totals disagree with its spread")

endmodule

bind minmax_spread_statistics mss_checker u_mss_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (stats_o.valid),
  .out_ready_i          (stats_o.ready),
  .spread_i             (stats_o.spread),
  .stats_valid_i        (stats_o.stats_valid),
  .bunch_count_i        (stats_o.bunch_count),
  .spread_sum_i         (stats_o.spread_sum),
  .spread_square_sum_i  (stats_o.spread_square_sum),
  .variance_numerator_i (stats_o.variance_numerator)
);

`default_nettype wire
